// ----- rtl/p2w_pkg.sv -----
package p2w_pkg;

   // Intermediate values: signed Q.16, magnitude held to 2^62-1
   typedef logic signed [62:0] q16_type;

   localparam logic [61:0] LIM_MAG = 62'h3FFF_FFFF_FFFF_FFFF;
   localparam q16_type ONE_Q16 = 63'sd65536;

   localparam int FRAC_W = 16;
   localparam int QUO_W = 32;
   localparam int DIV_STEPS = 4;
   localparam int DIV_LAT = QUO_W / DIV_STEPS + 1;
   localparam int PITCH_W = 32;

   // Configuration register indexes
   localparam logic [3:0] REG_CENTER = 4'd0;
   localparam logic [3:0] REG_PITCH = 4'd1;
   localparam logic [3:0] REG_K1 = 4'd2;
   localparam logic [3:0] REG_OFFSET = 4'd3;
   localparam logic [3:0] REG_XGAIN = 4'd4;
   localparam logic [3:0] REG_YGAIN = 4'd5;
   localparam logic [3:0] REG_DGAIN = 4'd6;
   localparam logic [3:0] REG_DOFFSET = 4'd7;

   // Result status codes
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_SAT = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd2;

   typedef struct packed {
      logic sat;
      q16_type val;
   } sat_q16_type;

   typedef struct packed {
      logic [QUO_W-1:0] quo;
      logic ovf;
      logic neg;
   } div_res_type;

endpackage

// ----- rtl/p2w_smul.sv -----
module p2w_smul #(
   parameter int AW = 32,
   parameter int BW = 32,
   parameter int SH = 16
) (
   input logic clock,
   input logic en,
   input logic signed [AW-1:0] a,
   input logic signed [BW-1:0] b,
   output p2w_pkg::q16_type p,
   output logic sat
);

   localparam int AL = AW / 2;
   localparam int AH = AW - AL;
   localparam int BL = BW / 2;
   localparam int BH = BW - BL;
   localparam int PW = AW + BW;

   logic [AW-1:0] a_mag;
   logic [BW-1:0] b_mag;
   logic [AL+BL-1:0] pll_ff;
   logic [AL+BH-1:0] plh_ff;
   logic [AH+BL-1:0] phl_ff;
   logic [AH+BH-1:0] phh_ff;
   logic neg_ff;
   logic [PW-1:0] prod;
   logic [PW-1:0] shd;
   logic ovf;
   logic [61:0] mag;
   p2w_pkg::q16_type p_in;
   p2w_pkg::q16_type p_ff;
   logic sat_ff;

   assign a_mag = a[AW-1] ? (~a) + 1'b1 : a;
   assign b_mag = b[BW-1] ? (~b) + 1'b1 : b;

   // first stage: four partial products of the magnitudes
   always_ff @(posedge clock) begin
      if (en) begin
         pll_ff <= a_mag[AL-1:0] * b_mag[BL-1:0];
         plh_ff <= a_mag[AL-1:0] * b_mag[BW-1:BL];
         phl_ff <= a_mag[AW-1:AL] * b_mag[BL-1:0];
         phh_ff <= a_mag[AW-1:AL] * b_mag[BW-1:BL];
         neg_ff <= a[AW-1] ^ b[BW-1];
      end
   end

   // second stage: sum, truncate toward zero, clamp magnitude
   always_comb begin
      prod = PW'(pll_ff) + (PW'(plh_ff) << BL) + (PW'(phl_ff) << AL)
           + (PW'(phh_ff) << (AL + BL));
      shd = prod >> SH;
      ovf = (shd > p2w_pkg::LIM_MAG);
      mag = ovf ? p2w_pkg::LIM_MAG : 62'(shd);
      p_in = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
         sat_ff <= ovf;
      end
   end

   assign p = p_ff;
   assign sat = sat_ff;

endmodule

// ----- rtl/p2w_div.sv -----
module p2w_div (
   input logic clock,
   input logic en,
   input p2w_pkg::q16_type num,
   input p2w_pkg::q16_type den,
   output p2w_pkg::div_res_type res
);

   localparam int QW = p2w_pkg::QUO_W;
   localparam int FW = p2w_pkg::FRAC_W;
   localparam int STEPS = p2w_pkg::DIV_STEPS;
   localparam int NST = QW / STEPS;

   logic [61:0] rem_ff [NST+1];
   logic [61:0] rem_in [NST+1];
   logic [61:0] dm_ff [NST+1];
   logic [61:0] dm_in [NST+1];
   logic [QW-1:0] nb_ff [NST+1];
   logic [QW-1:0] nb_in [NST+1];
   logic [QW-1:0] q_ff [NST+1];
   logic [QW-1:0] q_in [NST+1];
   logic ovf_ff [NST+1];
   logic ovf_in [NST+1];
   logic neg_ff [NST+1];
   logic neg_in [NST+1];

   always_comb begin
      logic [61:0] nm;
      logic [61:0] rem_w;
      logic [QW-1:0] nb_w;
      logic [QW-1:0] q_w;
      logic [62:0] trial;
      nm = num[62] ? 62'(-num) : 62'(num);
      dm_in[0] = den[62] ? 62'(-den) : 62'(den);
      // quotient needs more than QW bits when num >= den * 2^(QW-FW)
      ovf_in[0] = ({16'b0, nm} >= {dm_in[0], 16'b0});
      neg_in[0] = num[62] ^ den[62];
      rem_in[0] = nm >> (QW - FW);
      nb_in[0] = {nm[QW-FW-1:0], FW'(0)};
      q_in[0] = '0;
      for (int s = 1; s <= NST; s++) begin
         rem_w = rem_ff[s-1];
         nb_w = nb_ff[s-1];
         q_w = q_ff[s-1];
         for (int j = 0; j < STEPS; j++) begin
            trial = {rem_w, nb_w[QW-1]};
            nb_w = {nb_w[QW-2:0], 1'b0};
            if (trial >= {1'b0, dm_ff[s-1]}) begin
               trial = trial - {1'b0, dm_ff[s-1]};
               q_w = {q_w[QW-2:0], 1'b1};
            end else begin
               q_w = {q_w[QW-2:0], 1'b0};
            end
            rem_w = trial[61:0];
         end
         rem_in[s] = rem_w;
         nb_in[s] = nb_w;
         q_in[s] = q_w;
         dm_in[s] = dm_ff[s-1];
         ovf_in[s] = ovf_ff[s-1];
         neg_in[s] = neg_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= NST; s++) begin
            rem_ff[s] <= rem_in[s];
            dm_ff[s] <= dm_in[s];
            nb_ff[s] <= nb_in[s];
            q_ff[s] <= q_in[s];
            ovf_ff[s] <= ovf_in[s];
            neg_ff[s] <= neg_in[s];
         end
      end
   end

   assign res.quo = q_ff[NST];
   assign res.ovf = ovf_ff[NST];
   assign res.neg = neg_ff[NST];

endmodule

// ----- rtl/pixel_to_world_plane_mapper_unit.sv -----
// Maps a pixel position to ground-plane world coordinates (Tsai model with
// first-order radial distortion). Fully pipelined: one item enters per cycle
// unless a finished result is held, and each item runs through the products,
// the sums, the two restoring dividers (one setup stage and one stage per four
// quotient bits) and the output register; a stalled result freezes the whole pipeline.
// The nine Q16.16 plane coefficients, pitch, center and k1 come from the
// csr_ port, which must only be written while no item is in flight.
module pixel_to_world_plane_mapper_unit #(
   parameter int PIXEL_WIDTH = 16,
   parameter int COEF_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [15:0] req_pixel_x,
   input logic [15:0] req_pixel_y,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic signed [31:0] rsp_world_x,
   output logic signed [31:0] rsp_world_y,
   output logic [1:0] rsp_map_status,
   input logic csr_valid,
   output logic csr_ready,
   input logic [3:0] csr_index,
   input logic [63:0] csr_data
);

   localparam int PW = (PIXEL_WIDTH < 16) ? PIXEL_WIDTH : 16;
   localparam int CW = COEF_WIDTH;
   localparam int UW = PW + 18;
   localparam int RW = 2 * UW - 15;
   localparam int GW = RW + 8;
   localparam int LW = CW + UW - 15;
   localparam int DL = p2w_pkg::DIV_LAT;
   localparam int PIPE_LAT = 12 + DL;

   typedef struct packed {
      logic sat;
      logic [31:0] w;
   } clamp_type;

   function automatic p2w_pkg::sat_q16_type add_sat(input p2w_pkg::q16_type x,
                                                    input p2w_pkg::q16_type y);
      logic signed [63:0] s;
      logic [63:0] m;
      p2w_pkg::sat_q16_type r;
      s = 64'(x) + 64'(y);
      m = s[63] ? 64'(-s) : 64'(s);
      r.sat = (m > 64'(p2w_pkg::LIM_MAG));
      if (r.sat) begin
         m = 64'(p2w_pkg::LIM_MAG);
      end
      r.val = s[63] ? -$signed(m[62:0]) : $signed(m[62:0]);
      return r;
   endfunction

   function automatic clamp_type clamp_quo(input p2w_pkg::div_res_type r);
      clamp_type c;
      logic [31:0] q;
      q = r.quo;
      c.sat = 1'b0;
      if (r.neg) begin
         if (r.ovf || q > 32'h8000_0000) begin
            c.sat = 1'b1;
            q = 32'h8000_0000;
         end
         c.w = -q;
      end else begin
         if (r.ovf || q > 32'h7FFF_FFFF) begin
            c.sat = 1'b1;
            q = 32'h7FFF_FFFF;
         end
         c.w = q;
      end
      return c;
   endfunction

   logic [31:0] center_ff;
   logic [63:0] pitch_ff;
   logic [31:0] k1_ff;
   logic [63:0] offset_ff;
   logic [63:0] xgain_ff;
   logic [63:0] ygain_ff;
   logic [63:0] dgain_ff;
   logic [31:0] doffset_ff;

   logic adv;
   logic vld_ff [PIPE_LAT];

   logic signed [PW:0] dx;
   logic signed [PW:0] dy;
   p2w_pkg::q16_type u_p, v_p, v_val;
   p2w_pkg::q16_type uu_p, vv_p;
   p2w_pkg::q16_type mx1_p, mx2_p, my1_p, my2_p, md1_p, md2_p;
   p2w_pkg::q16_type kr_p;
   p2w_pkg::q16_type gx_p, gy_p, gd_p;
   logic gx_sat, gy_sat, gd_sat;

   p2w_pkg::sat_q16_type r2_in, linx_in, liny_in, lind_in, g_in;
   p2w_pkg::q16_type r2_ff;
   p2w_pkg::q16_type linx_ff [4];
   p2w_pkg::q16_type liny_ff [4];
   p2w_pkg::q16_type lind_ff [4];
   p2w_pkg::q16_type g_ff;
   p2w_pkg::q16_type nx_ff, ny_ff, den_ff;
   logic sat11_ff;
   p2w_pkg::sat_q16_type nx_in, ny_in, den_in;

   logic sat_dly_ff [DL];
   logic zero_dly_ff [DL];
   p2w_pkg::div_res_type resx, resy;
   clamp_type cx_in, cy_in;

   logic signed [31:0] wx_ff, wx_in;
   logic signed [31:0] wy_ff, wy_in;
   logic [1:0] status_ff, status_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         pitch_ff <= '0;
         k1_ff <= '0;
         offset_ff <= '0;
         xgain_ff <= '0;
         ygain_ff <= '0;
         dgain_ff <= '0;
         doffset_ff <= 32'd65536;
      end else if (csr_valid) begin
         unique case (csr_index)
            p2w_pkg::REG_CENTER: center_ff <= csr_data[31:0];
            p2w_pkg::REG_PITCH: pitch_ff <= csr_data;
            p2w_pkg::REG_K1: k1_ff <= csr_data[31:0];
            p2w_pkg::REG_OFFSET: offset_ff <= csr_data;
            p2w_pkg::REG_XGAIN: xgain_ff <= csr_data;
            p2w_pkg::REG_YGAIN: ygain_ff <= csr_data;
            p2w_pkg::REG_DGAIN: dgain_ff <= csr_data;
            p2w_pkg::REG_DOFFSET: doffset_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // the whole pipeline advances unless the finished item is held
   assign adv = !vld_ff[PIPE_LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   assign dx = $signed({1'b0, req_pixel_x[PW-1:0]}) - $signed({1'b0, center_ff[16 +: PW]});
   assign dy = $signed({1'b0, req_pixel_y[PW-1:0]}) - $signed({1'b0, center_ff[0 +: PW]});

   p2w_smul #(.AW(PW + 1), .BW(p2w_pkg::PITCH_W + 1), .SH(16)) u_mul_u (
      .clock(clock), .en(adv), .a(dx), .b({1'b0, pitch_ff[63:32]}), .p(u_p), .sat());
   p2w_smul #(.AW(PW + 1), .BW(p2w_pkg::PITCH_W + 1), .SH(16)) u_mul_v (
      .clock(clock), .en(adv), .a(dy), .b({1'b0, pitch_ff[31:0]}), .p(v_p), .sat());

   assign v_val = -v_p;

   p2w_smul #(.AW(UW), .BW(UW), .SH(16)) u_mul_uu (
      .clock(clock), .en(adv), .a(u_p[UW-1:0]), .b(u_p[UW-1:0]), .p(uu_p), .sat());
   p2w_smul #(.AW(UW), .BW(UW), .SH(16)) u_mul_vv (
      .clock(clock), .en(adv), .a(v_val[UW-1:0]), .b(v_val[UW-1:0]), .p(vv_p), .sat());
   p2w_smul #(.AW(CW), .BW(UW), .SH(16)) u_mul_x1 (
      .clock(clock), .en(adv), .a(xgain_ff[32 +: CW]), .b(u_p[UW-1:0]), .p(mx1_p), .sat());
   p2w_smul #(.AW(CW), .BW(UW), .SH(16)) u_mul_x2 (
      .clock(clock), .en(adv), .a(xgain_ff[0 +: CW]), .b(v_val[UW-1:0]), .p(mx2_p), .sat());
   p2w_smul #(.AW(CW), .BW(UW), .SH(16)) u_mul_y1 (
      .clock(clock), .en(adv), .a(ygain_ff[32 +: CW]), .b(u_p[UW-1:0]), .p(my1_p), .sat());
   p2w_smul #(.AW(CW), .BW(UW), .SH(16)) u_mul_y2 (
      .clock(clock), .en(adv), .a(ygain_ff[0 +: CW]), .b(v_val[UW-1:0]), .p(my2_p), .sat());
   p2w_smul #(.AW(CW), .BW(UW), .SH(16)) u_mul_d1 (
      .clock(clock), .en(adv), .a(dgain_ff[32 +: CW]), .b(u_p[UW-1:0]), .p(md1_p), .sat());
   p2w_smul #(.AW(CW), .BW(UW), .SH(16)) u_mul_d2 (
      .clock(clock), .en(adv), .a(dgain_ff[0 +: CW]), .b(v_val[UW-1:0]), .p(md2_p), .sat());

   // r2 and the three linear terms; their ranges keep them clear of saturation
   always_comb begin
      r2_in = add_sat(uu_p, vv_p);
      linx_in = add_sat(mx1_p, mx2_p);
      liny_in = add_sat(my1_p, my2_p);
      lind_in = add_sat(md1_p, md2_p);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r2_ff <= r2_in.val;
         linx_ff[0] <= linx_in.val;
         liny_ff[0] <= liny_in.val;
         lind_ff[0] <= lind_in.val;
         for (int i = 1; i < 4; i++) begin
            linx_ff[i] <= linx_ff[i-1];
            liny_ff[i] <= liny_ff[i-1];
            lind_ff[i] <= lind_ff[i-1];
         end
      end
   end

   p2w_smul #(.AW(32), .BW(RW), .SH(24)) u_mul_k1 (
      .clock(clock), .en(adv), .a(k1_ff), .b(r2_ff[RW-1:0]), .p(kr_p), .sat());

   always_comb begin
      g_in = add_sat(p2w_pkg::ONE_Q16, kr_p);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_ff <= g_in.val;
      end
   end

   p2w_smul #(.AW(GW), .BW(LW), .SH(16)) u_mul_gx (
      .clock(clock), .en(adv), .a(g_ff[GW-1:0]), .b(linx_ff[3][LW-1:0]),
      .p(gx_p), .sat(gx_sat));
   p2w_smul #(.AW(GW), .BW(LW), .SH(16)) u_mul_gy (
      .clock(clock), .en(adv), .a(g_ff[GW-1:0]), .b(liny_ff[3][LW-1:0]),
      .p(gy_p), .sat(gy_sat));
   p2w_smul #(.AW(GW), .BW(LW), .SH(16)) u_mul_gd (
      .clock(clock), .en(adv), .a(g_ff[GW-1:0]), .b(lind_ff[3][LW-1:0]),
      .p(gd_p), .sat(gd_sat));

   always_comb begin
      nx_in = add_sat(p2w_pkg::q16_type'($signed(offset_ff[32 +: CW])), gx_p);
      ny_in = add_sat(p2w_pkg::q16_type'($signed(offset_ff[0 +: CW])), gy_p);
      den_in = add_sat(p2w_pkg::q16_type'($signed(doffset_ff[0 +: CW])), gd_p);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff <= nx_in.val;
         ny_ff <= ny_in.val;
         den_ff <= den_in.val;
         sat11_ff <= gx_sat | gy_sat | gd_sat | nx_in.sat | ny_in.sat | den_in.sat;
      end
   end

   p2w_div u_div_x (.clock(clock), .en(adv), .num(nx_ff), .den(den_ff), .res(resx));
   p2w_div u_div_y (.clock(clock), .en(adv), .num(ny_ff), .den(den_ff), .res(resy));

   // carry flags alongside the dividers
   always_ff @(posedge clock) begin
      if (adv) begin
         sat_dly_ff[0] <= sat11_ff;
         zero_dly_ff[0] <= (den_ff == '0);
         for (int i = 1; i < DL; i++) begin
            sat_dly_ff[i] <= sat_dly_ff[i-1];
            zero_dly_ff[i] <= zero_dly_ff[i-1];
         end
      end
   end

   always_comb begin
      cx_in = clamp_quo(resx);
      cy_in = clamp_quo(resy);
      if (zero_dly_ff[DL-1]) begin
         wx_in = '0;
         wy_in = '0;
         status_in = p2w_pkg::STATUS_ZERO_DEN;
      end else begin
         wx_in = $signed(cx_in.w);
         wy_in = $signed(cy_in.w);
         status_in = (sat_dly_ff[DL-1] || cx_in.sat || cy_in.sat) ?
                     p2w_pkg::STATUS_SAT : p2w_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wx_ff <= wx_in;
         wy_ff <= wy_in;
         status_ff <= status_in;
      end
   end

   assign rsp_world_x = wx_ff;
   assign rsp_world_y = wy_ff;
   assign rsp_map_status = status_ff;

endmodule
